FILE: rtl/nps3d_pkg.sv
`timescale 1ns / 1ps
// nps3d_pkg: constants, widths and types shared by the nearest point search.
// No dependencies.
package nps3d_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int COORD_BITS = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int DIST_W     = 2 * COORD_BITS + 2;
  localparam int SQ_W       = 2 * COORD_BITS;
  localparam int PT_W       = 3 * COORD_BITS;
  localparam int ADDR_W     = 3;
  localparam int IN_DATA_W  = ((IDX_W + PT_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((IDX_W + DIST_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0] REF_COUNT_RST = CNT_W'(MAX_POINTS);

  typedef enum logic {
    REG_REF_COUNT = 1'b0,
    REG_NONE      = 1'b1
  } reg_idx_t;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

FILE: rtl/nearest_point_search_3d.sv
`timescale 1ns / 1ps
// nearest_point_search_3d: point store plus pipelined squared-distance unit
// and running minimum under a small sequencer. Depends on nps3d_pkg.
//
// Usage: in_tuser = 0 loads a reference point into store slot in_tdata[9:0];
// in_tuser = 1 is a query. A query scans stored points 0..ref_count-1 (ref_count
// at cfg byte address 0, saturated to 1024) and returns one result on the out
// channel: index of the nearest point (lowest index on ties) and the exact
// squared distance. Loads return nothing.
// Throughput: loads are accepted back to back. A query with ref_count 0 skips the
// scan; otherwise one stored point enters the distance pipeline per cycle (memory
// read, difference, square, sum, compare), so the scan length sets the rate.
// in_tready is low from the query transfer until its result is registered.
// The result sits in an output register; a new item is taken while it waits.
// If the receiver still stalls when the next query finishes, that query
// holds in its last state until the register frees.
// Reset: ref_count returns to 1024, no result pending. The store is not
// cleared; scanning a never-loaded slot gives undefined results.
module nearest_point_search_3d (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [9:0] slot, [25:10] coord_x, [41:26] coord_y, [57:42] coord_z
  input  logic [nps3d_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] kind
  input  logic                              in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [9:0] nearest_index, [43:10] nearest_sq_distance
  output logic [nps3d_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [nps3d_pkg::ADDR_W-1:0]      cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import nps3d_pkg::*;

  state_t state_r, state_nxt;

  logic [CNT_W-1:0] ref_count_r;
  logic [CNT_W-1:0] cnt_eff_r;
  logic [CNT_W-1:0] cnt_sat;
  logic [CNT_W-1:0] iss_r;
  logic [CNT_W-1:0] iss_inc;

  coord_t qx_r, qy_r, qz_r;
  logic [PT_W-1:0] mem [MAX_POINTS];
  logic [PT_W-1:0] rd_data_r;

  logic v1_r, v2_r, v3_r, v4_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r, idx4_r;
  logic [COORD_BITS-1:0] magx_r, magy_r, magz_r;
  logic [SQ_W-1:0] sqx_r, sqy_r, sqz_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] best_d_r;
  logic [IDX_W-1:0] best_idx_r;

  logic out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [DIST_W-1:0] out_dist_r;

  logic in_xfer, load_xfer, query_xfer, cfg_wr;
  logic issue_en, load_out, pipe_busy;

  logic [IDX_W-1:0] slot_in;
  coord_t cx_in, cy_in, cz_in;
  logic signed [COORD_BITS:0] dx, dy, dz;
  coord_t rx, ry, rz;

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    if (reg_idx_t'(cfg_paddr[2]) == REG_REF_COUNT) begin
      cfg_prdata = 32'(ref_count_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_count_r <= REF_COUNT_RST;
    end else if (cfg_wr && reg_idx_t'(cfg_paddr[2]) == REG_REF_COUNT) begin
      ref_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // input decode
  assign slot_in    = in_tdata[IDX_W-1:0];
  assign cx_in      = in_tdata[IDX_W +: COORD_BITS];
  assign cy_in      = in_tdata[IDX_W+COORD_BITS +: COORD_BITS];
  assign cz_in      = in_tdata[IDX_W+2*COORD_BITS +: COORD_BITS];
  assign in_xfer    = in_tvalid && in_tready;
  assign load_xfer  = in_xfer && kind_t'(in_tuser) == KIND_LOAD;
  assign query_xfer = in_xfer && kind_t'(in_tuser) == KIND_QUERY;
  assign cnt_sat    = (ref_count_r > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : ref_count_r;
  assign iss_inc    = CNT_W'(iss_r + CNT_W'(1));
  assign pipe_busy  = v1_r || v2_r || v3_r || v4_r;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (query_xfer) begin
          state_nxt = (cnt_sat == '0) ? S_DONE : S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_inc == cnt_eff_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    issue_en  = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      S_IDLE:  in_tready = 1'b1;
      S_SCAN:  issue_en  = 1'b1;
      S_DRAIN: ;
      S_DONE:  load_out  = !out_valid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (query_xfer) begin
      qx_r      <= cx_in;
      qy_r      <= cy_in;
      qz_r      <= cz_in;
      cnt_eff_r <= cnt_sat;
      iss_r     <= '0;
    end else if (issue_en) begin
      iss_r <= iss_inc;
    end
  end

  // point store
  always_ff @(posedge clk) begin
    if (load_xfer && CNT_W'(slot_in) < CNT_W'(MAX_POINTS)) begin
      mem[slot_in] <= {cz_in, cy_in, cx_in};
    end
    rd_data_r <= mem[iss_r[IDX_W-1:0]];
  end

  // distance pipeline
  assign rx = rd_data_r[0 +: COORD_BITS];
  assign ry = rd_data_r[COORD_BITS +: COORD_BITS];
  assign rz = rd_data_r[2*COORD_BITS +: COORD_BITS];
  assign dx = (COORD_BITS+1)'(rx) - (COORD_BITS+1)'(qx_r);
  assign dy = (COORD_BITS+1)'(ry) - (COORD_BITS+1)'(qy_r);
  assign dz = (COORD_BITS+1)'(rz) - (COORD_BITS+1)'(qz_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= issue_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    idx1_r <= iss_r[IDX_W-1:0];
    idx2_r <= idx1_r;
    idx3_r <= idx2_r;
    idx4_r <= idx3_r;
    magx_r <= COORD_BITS'(dx[COORD_BITS] ? -dx : dx);
    magy_r <= COORD_BITS'(dy[COORD_BITS] ? -dy : dy);
    magz_r <= COORD_BITS'(dz[COORD_BITS] ? -dz : dz);
    sqx_r  <= SQ_W'(magx_r) * SQ_W'(magx_r);
    sqy_r  <= SQ_W'(magy_r) * SQ_W'(magy_r);
    sqz_r  <= SQ_W'(magz_r) * SQ_W'(magz_r);
    dist_r <= DIST_W'(sqx_r) + DIST_W'(sqy_r) + DIST_W'(sqz_r);
  end

  // running minimum, first index wins ties
  always_ff @(posedge clk) begin
    if (query_xfer) begin
      best_d_r   <= '0;
      best_idx_r <= '0;
    end else if (v4_r && (idx4_r == '0 || dist_r < best_d_r)) begin
      best_d_r   <= dist_r;
      best_idx_r <= idx4_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx_r  <= best_idx_r;
      out_dist_r <= best_d_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'({out_dist_r, out_idx_r});

  // checks
  a_pipe_idle_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |-> !pipe_busy)
    else $error("distance pipeline busy when result formed");

  a_tokens_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("distance token outside a scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside done state");

  a_no_overscan: assert property (@(posedge clk) disable iff (!rst_n)
    issue_en |-> (iss_r < cnt_eff_r && cnt_eff_r <= CNT_W'(MAX_POINTS)))
    else $error("scan issued past point count");

endmodule

FILE: tb/nearest_point_search_3d_test.sv
`timescale 1ns / 1ps
// nearest_point_search_3d_test: self-checking bench for the 3D nearest point search.
// Drives loads, queries and ref_count writes, predicts every result in-bench.
// Depends on nps3d_pkg and nearest_point_search_3d.
module nearest_point_search_3d_test;
  import nps3d_pkg::*;

  localparam int RANDOM_ITEMS = 580;
  localparam int FILL_AFTER   = 200;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_PAD    = 16;
  localparam int END_PAD      = 32;
  localparam int QUIET_LIMIT  = 8000;

  typedef struct packed {
    logic [DIST_W-1:0] sq_dist;
    logic [IDX_W-1:0]  index;
  } nearest_t;

  typedef enum {OP_LOAD, OP_QUERY, OP_CFG} step_op_t;

  typedef struct {
    step_op_t         op;
    logic [IDX_W-1:0] slot;
    coord_t           x, y, z;
    reg_idx_t         reg_sel;
    logic [31:0]      wdata;
    bit               typed;
    nearest_t         typed_res;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [ADDR_W-1:0]     cfg_paddr;
  logic [31:0]           cfg_pwdata;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  nearest_point_search_3d uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // bench copy of the block state
  coord_t           store_x [MAX_POINTS];
  coord_t           store_y [MAX_POINTS];
  coord_t           store_z [MAX_POINTS];
  bit               written [MAX_POINTS];
  logic [CNT_W-1:0] ref_count_q = REF_COUNT_RST;

  nearest_t expected_nearest [$];
  step_t    directed_steps [$];

  int mismatches  = 0;
  int loads       = 0;
  int queries     = 0;
  int results     = 0;
  int cfg_writes  = 0;
  int burst_left  = 0;
  bit no_gaps     = 1'b0;
  int hold_reqs   = 0;
  int hold_seen   = 0;
  int hold_left   = 0;
  int stall_left  = 0;
  int mode_left   = 0;
  bit fast_mode   = 1'b0;
  int quiet       = 0;
  nearest_t head;

  function automatic void note_mismatch(input string what, input longint want,
                                        input longint got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %0s: expected %0d, got %0d at %0t", what, want, got, $time);
  endfunction

  function automatic nearest_t find_nearest(input coord_t qx, input coord_t qy,
                                            input coord_t qz);
    nearest_t best;
    longint   dx, dy, dz, d;
    int       n;
    best = '0;
    n = (ref_count_q > MAX_POINTS) ? MAX_POINTS : int'(ref_count_q);
    for (int k = 0; k < n; k++) begin
      dx = longint'(store_x[k]) - longint'(qx);
      dy = longint'(store_y[k]) - longint'(qy);
      dz = longint'(store_z[k]) - longint'(qz);
      d = dx * dx + dy * dy + dz * dz;
      if (k == 0 || d < longint'(best.sq_dist)) begin
        best.sq_dist = DIST_W'(d);
        best.index   = IDX_W'(k);
      end
    end
    return best;
  endfunction

  function automatic int written_prefix();
    int k;
    k = 0;
    while (k < MAX_POINTS && written[k])
      k++;
    return k;
  endfunction

  function automatic coord_t rand_coord(input int style);
    case (style)
      1: return coord_t'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 3))
          0: return coord_t'(-32768);
          1: return coord_t'(32767);
          2: return coord_t'(-1);
          default: return coord_t'(0);
        endcase
      end
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic void add_item(input step_op_t op, input logic [IDX_W-1:0] slot,
                                   input int x, input int y, input int z,
                                   input bit typed, input int idx, input longint sq);
    step_t s;
    s.op                = op;
    s.slot              = slot;
    s.x                 = coord_t'(x);
    s.y                 = coord_t'(y);
    s.z                 = coord_t'(z);
    s.reg_sel           = REG_REF_COUNT;
    s.wdata             = '0;
    s.typed             = typed;
    s.typed_res.index   = IDX_W'(idx);
    s.typed_res.sq_dist = DIST_W'(sq);
    directed_steps.push_back(s);
  endfunction

  function automatic void add_cfg(input reg_idx_t sel, input logic [31:0] wdata);
    step_t s;
    s.op        = OP_CFG;
    s.slot      = '0;
    s.x         = '0;
    s.y         = '0;
    s.z         = '0;
    s.reg_sel   = sel;
    s.wdata     = wdata;
    s.typed     = 1'b0;
    s.typed_res = '0;
    directed_steps.push_back(s);
  endfunction

  task automatic send_item(input kind_t kind, input logic [IDX_W-1:0] slot,
                           input coord_t x, input coord_t y, input coord_t z,
                           input bit typed, input nearest_t typed_res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = no_gaps ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= IN_DATA_W'({z, y, x, slot});
    do @(posedge clk); while (!in_tready);
    if (kind == KIND_LOAD) begin
      store_x[slot] = x;
      store_y[slot] = y;
      store_z[slot] = z;
      written[slot] = 1'b1;
      loads++;
    end else begin
      expected_nearest.push_back(typed ? typed_res : find_nearest(x, y, z));
      queries++;
    end
  endtask

  task automatic send_random(input kind_t kind, input logic [IDX_W-1:0] slot,
                             input int style);
    int s;
    s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : style;
    send_item(kind, slot, rand_coord(s), rand_coord(s), rand_coord(s), 1'b0, '0);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_nearest.size() != 0)
      @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  task automatic cfg_xfer(input bit wr, input reg_idx_t sel, input logic [31:0] wdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ADDR_W'({sel, 2'b00});
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (wr) begin
      if (sel == REG_REF_COUNT)
        ref_count_q = wdata[CNT_W-1:0];
      cfg_writes++;
    end else if (cfg_prdata[CNT_W-1:0] !== ref_count_q) begin
      note_mismatch("ref_count readback", ref_count_q, cfg_prdata[CNT_W-1:0]);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // write while idle, then read ref_count back
  task automatic program_reg(input reg_idx_t sel, input logic [31:0] wdata);
    wait_drain();
    cfg_xfer(1'b1, sel, wdata);
    cfg_xfer(1'b0, REG_REF_COUNT, '0);
  endtask

  // receiver: own stall pattern, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        fast_mode = ($urandom_range(0, 2) == 0);
        mode_left = $urandom_range(50, 400);
      end
      mode_left--;
      if (fast_mode) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 19);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results++;
      if (expected_nearest.size() == 0) begin
        note_mismatch("unexpected result, index", -1, out_tdata[IDX_W-1:0]);
      end else begin
        head = expected_nearest.pop_front();
        if (out_tdata[IDX_W-1:0] !== head.index)
          note_mismatch("nearest_index", head.index, out_tdata[IDX_W-1:0]);
        if (out_tdata[IDX_W+DIST_W-1:IDX_W] !== head.sq_dist)
          note_mismatch("nearest_sq_distance", head.sq_dist,
                        out_tdata[IDX_W+DIST_W-1:IDX_W]);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
        quiet = 0;
      else
        quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    int               items_done;
    int               pre;
    int               cnt;
    int               n;
    int               style;
    int               phase;
    bit               full;
    bit               wide_cnt;
    logic [IDX_W-1:0] slot;
    logic [31:0]      wdata;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= KIND_LOAD;
    out_tready  <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of ref_count
    cfg_xfer(1'b0, REG_REF_COUNT, '0);

    add_cfg(REG_REF_COUNT, 32'd4);
    add_item(OP_LOAD,  10'd0,    -32768, -32768, -32768, 1'b0, 0, 0);
    add_item(OP_LOAD,  10'd1,     32767,  32767,  32767, 1'b0, 0, 0);
    add_item(OP_LOAD,  10'd2,         0,      0,      0, 1'b0, 0, 0);
    add_item(OP_LOAD,  10'd3,         0,      0,      0, 1'b0, 0, 0);
    // tie between slots 2 and 3: lower index
    add_item(OP_QUERY, 10'd0,         0,      0,      0, 1'b1, 2, 0);
    add_item(OP_QUERY, 10'd0,     32767,  32767,  32767, 1'b1, 1, 0);
    add_item(OP_QUERY, 10'd0,    -32768, -32768, -32768, 1'b1, 0, 0);
    add_item(OP_QUERY, 10'd0,         1,      0,      0, 1'b1, 2, 1);
    add_item(OP_QUERY, 10'd0,        -1,     -1,     -1, 1'b1, 2, 3);
    add_item(OP_QUERY, 10'd0,    -32768,  32767,      0, 1'b0, 0, 0);
    add_item(OP_LOAD,  10'd1023,      5,      5,      5, 1'b0, 0, 0);
    // slot field is don't-care on a query
    add_item(OP_QUERY, 10'd1023,      0,      0,      0, 1'b1, 2, 0);
    add_cfg(REG_REF_COUNT, 32'd1);
    add_item(OP_QUERY, 10'd0,     32767,  32767,  32767, 1'b1, 0, 64'd12884508675);
    add_cfg(REG_REF_COUNT, 32'd0);
    add_item(OP_QUERY, 10'd0,       123,    -45,      6, 1'b1, 0, 0);
    // unmapped register: count stays 0
    add_cfg(REG_NONE, 32'd7);
    add_item(OP_QUERY, 10'd0,         1,      1,      1, 1'b1, 0, 0);
    add_cfg(REG_REF_COUNT, 32'hFFFF_F802);
    add_item(OP_QUERY, 10'd0,         1,      1,      1, 1'b0, 0, 0);
    add_item(OP_QUERY, 10'd0,    -32768, -32768,  32767, 1'b0, 0, 0);

    foreach (directed_steps[i]) begin
      if (directed_steps[i].op == OP_CFG)
        program_reg(directed_steps[i].reg_sel, directed_steps[i].wdata);
      else
        send_item((directed_steps[i].op == OP_LOAD) ? KIND_LOAD : KIND_QUERY,
                  directed_steps[i].slot, directed_steps[i].x, directed_steps[i].y,
                  directed_steps[i].z, directed_steps[i].typed,
                  directed_steps[i].typed_res);
    end

    items_done = 0;
    phase      = 0;
    full       = 1'b0;
    while (items_done < RANDOM_ITEMS) begin
      if (!full && items_done >= FILL_AFTER) begin
        no_gaps = 1'b0;
        for (int s = 0; s < MAX_POINTS; s++)
          send_random(KIND_LOAD, IDX_W'(s), $urandom_range(0, 2));
        full = 1'b1;
      end
      pre      = written_prefix();
      wide_cnt = full && ($urandom_range(0, 3) == 0);
      if (wide_cnt) begin
        case ($urandom_range(0, 4))
          0: cnt = MAX_POINTS;
          1: cnt = MAX_POINTS + 1;
          2: cnt = 2047;
          3: cnt = 0;
          default: cnt = $urandom_range(0, 2047);
        endcase
      end else if ($urandom_range(0, 11) == 0) begin
        cnt = 0;
      end else begin
        cnt = $urandom_range(1, (pre < 40) ? pre : 40);
      end
      if ($urandom_range(0, 7) == 0)
        program_reg(REG_NONE, $urandom);
      wdata = {(($urandom_range(0, 3) == 0) ? 21'($urandom) : 21'd0), 11'(cnt)};
      program_reg(REG_REF_COUNT, wdata);

      if (phase == 2 || phase == 9)
        hold_reqs <= hold_reqs + 1;
      no_gaps = ($urandom_range(0, 2) == 0);
      style   = $urandom_range(0, 2);
      n       = wide_cnt ? 5 : $urandom_range(20, 50);
      repeat (n) begin
        if ($urandom_range(0, 9) < 4) begin
          if (full || $urandom_range(0, 7) == 0)
            slot = IDX_W'($urandom);
          else
            slot = IDX_W'($urandom_range(0, (pre + 3 < MAX_POINTS - 1) ? pre + 3
                                                                       : MAX_POINTS - 1));
          send_random(KIND_LOAD, slot, style);
        end else begin
          send_random(KIND_QUERY, IDX_W'($urandom), style);
        end
        items_done++;
      end
      phase++;
    end

    wait_drain();
    repeat (END_PAD) @(posedge clk);
    if (expected_nearest.size() != 0)
      note_mismatch("results never delivered", expected_nearest.size(), 0);

    $display("covered %0d loads (full store fill included), %0d queries, %0d results",
             loads, queries, results);
    $display("%0d register writes over %0d phases, %0d mismatches",
             cfg_writes, phase, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
